// File: rtl/fspc_pkg.sv
// Package: instruction fields, pipeline latch types and transfer payloads.
`timescale 1ns / 1ps
`default_nettype none
package fspc_pkg;

    localparam int MEM_WORDS = 4096;            // power of two
    localparam int AW        = $clog2(MEM_WORDS);

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_NOR     = 4'd1;
    localparam logic [3:0] OP_LW      = 4'd2;
    localparam logic [3:0] OP_SW      = 4'd3;
    localparam logic [3:0] OP_BEQ     = 4'd4;
    localparam logic [3:0] OP_JALR    = 4'd5;
    localparam logic [3:0] OP_HALT    = 4'd6;
    localparam logic [3:0] OP_UNKNOWN = 4'd8;

    localparam logic [31:0] NOOP_WORD = 32'h01C0_0000;

    localparam logic [1:0] FN_LOAD = 2'd0;
    localparam logic [1:0] FN_RUN  = 2'd1;
    localparam logic [1:0] FN_RDM  = 2'd2;
    localparam logic [1:0] FN_RREG = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        addr;
        logic signed [31:0] load_value;
    } t_in;

    typedef struct packed {
        logic               halted;
        logic [15:0]        pc_now;
        logic [31:0]        cycle_count;
        logic signed [31:0] read_value;
        logic               wb_valid;
        logic [2:0]         wb_reg;
        logic signed [31:0] wb_data;
        logic               store_valid;
        logic [15:0]        store_addr;
        logic signed [31:0] store_data;
    } t_out;

    typedef struct packed {
        logic [31:0] ins;
        logic [15:0] pcp1;
    } t_fd;

    typedef struct packed {
        logic [31:0] ins;
        logic [15:0] pcp1;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] off;
    } t_de;

    typedef struct packed {
        logic [31:0] ins;
        logic [31:0] target;
        logic        eq;
        logic [31:0] alu;
        logic [31:0] vb;
    } t_em;

    typedef struct packed {
        logic [31:0] ins;
        logic [31:0] data;
    } t_wl;

    typedef struct packed {
        logic       v;
        logic [2:0] r;
    } t_dest;

    function automatic logic [3:0] op_of(input logic [31:0] w);
        if (w[31:25] != 7'd0) return OP_UNKNOWN;
        return {1'b0, w[24:22]};
    endfunction

    function automatic logic [2:0] ra_of(input logic [31:0] w);
        return w[21:19];
    endfunction

    function automatic logic [2:0] rb_of(input logic [31:0] w);
        return w[18:16];
    endfunction

    function automatic t_dest dest_of(input logic [31:0] w);
        t_dest d;
        logic [3:0] op;
        op = op_of(w);
        d.v = 1'b0;
        d.r = 3'd0;
        if (op == OP_ADD || op == OP_NOR) begin
            d.v = 1'b1;
            d.r = w[2:0];
        end else if (op == OP_LW) begin
            d.v = 1'b1;
            d.r = w[18:16];
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// File: rtl/five_stage_pipelined_cpu.sv
// Top level: five-stage pipeline with forwarding, memories and output queue.
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in  (t_in)
//  out     | output    | o_out_valid / i_out_stall| o_out (t_out)
//
// One item per cycle unless o_in_stall is high; each result passes through r_p, then the output queue.
// Instruction and lw words are read ahead into registers from the next pc and
// next EX/MEM address, with bypass of a same-cycle write.
// After reset both memories are cleared word by word, with o_in_stall high.
// A two-entry output queue absorbs stalls on the output side.
`timescale 1ns / 1ps
`default_nettype none
module five_stage_pipelined_cpu import fspc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    logic [31:0] r_imem [MEM_WORDS];
    logic [31:0] r_dmem [MEM_WORDS];
    logic [31:0] r_rf [8];

    logic [15:0] r_pc, n_pc;
    logic [31:0] r_cyc, n_cyc;
    t_fd r_fd, n_fd;
    t_de r_de, n_de;
    t_em r_em, n_em;
    t_wl r_mw, n_mw, r_we;

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic [31:0] r_imem_q, r_if_bd, r_dma_q, r_dma_bd, r_dmb_q;
    logic        r_if_byp, r_dma_byp;
    logic [31:0] if_word, lw_word;

    logic          acc, run, halted;
    logic          im_we, dm_we;
    logic [AW-1:0] im_wa, dm_wa, im_ra, dma_ra;
    logic [31:0]   im_wd, dm_wd;
    logic          rf_we;
    logic [2:0]    rf_wa;
    t_out          n_res;

    logic   r_p_valid, r_p_dsel;
    t_out   r_p;
    t_out   r_q [2];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    logic   push, pop;
    t_out   p_res;

    assign halted  = (op_of(r_mw.ins) == OP_HALT);
    assign pop     = (r_cnt != 2'd0) && !i_out_stall;
    assign push    = r_p_valid && ((r_cnt != 2'd2) || pop);
    assign o_in_stall = r_clearing || (r_p_valid && !push);
    assign acc     = i_in_valid && !o_in_stall;
    assign run     = acc && (i_in.func == FN_RUN) && !halted;
    assign if_word = r_if_byp  ? r_if_bd  : r_imem_q;
    assign lw_word = r_dma_byp ? r_dma_bd : r_dma_q;

    always_comb begin
        logic [31:0] cur, a, b, o;
        logic [3:0]  op, eop, wop, nop;
        logic        useb, hit;
        t_dest       d;
        logic [AW-1:0] ad;

        n_pc  = r_pc;
        n_cyc = r_cyc;
        n_fd  = r_fd;
        n_de  = r_de;
        n_em  = r_em;
        n_mw  = r_mw;
        rf_we = 1'b0;
        rf_wa = 3'd0;
        n_res = '0;
        cur = 32'd0; a = 32'd0; b = 32'd0; o = 32'd0;
        op = 4'd0; eop = 4'd0; wop = 4'd0; nop = 4'd0;
        useb = 1'b0; hit = 1'b0; d = '0; ad = '0;

        if (run) begin
            n_cyc = r_cyc + 32'd1;
            n_fd.pcp1 = r_pc + 16'd1;
            n_fd.ins  = if_word;
            n_pc      = r_pc + 16'd1;

            o = {16'd0, r_fd.ins[15:0]};
            n_de.pcp1 = r_fd.pcp1;
            n_de.va   = r_rf[ra_of(r_fd.ins)];
            n_de.vb   = r_rf[rb_of(r_fd.ins)];
            n_de.off  = o[15] ? (o | 32'hFFFF_0000) : o;
            n_de.ins  = r_fd.ins;

            cur = r_de.ins;
            op  = op_of(cur);
            n_em.target = {16'd0, r_de.pcp1} + r_de.off;
            n_em.ins    = cur;
            n_em.vb     = r_de.vb;

            if (op == OP_LW) begin
                nop = op_of(r_fd.ins);
                if (nop == OP_ADD || nop == OP_NOR || nop == OP_BEQ || nop == OP_SW)
                    hit = (rb_of(cur) == ra_of(r_fd.ins)) || (rb_of(cur) == rb_of(r_fd.ins));
                else if (nop == OP_LW)
                    hit = (rb_of(cur) == ra_of(r_fd.ins));
                if (hit) begin
                    n_fd     = r_fd;
                    n_pc     = r_pc;
                    n_de.ins = NOOP_WORD;
                end
            end

            if (op <= OP_BEQ) begin
                a    = r_de.va;
                b    = r_de.vb;
                useb = (op != OP_LW);
                eop  = op_of(r_em.ins);
                d = dest_of(r_we.ins);
                if (d.v) begin
                    if (d.r == ra_of(cur)) a = r_we.data;
                    if (useb && d.r == rb_of(cur)) b = r_we.data;
                end
                d = dest_of(r_mw.ins);
                if (d.v) begin
                    if (d.r == ra_of(cur)) a = r_mw.data;
                    if (useb && d.r == rb_of(cur)) b = r_mw.data;
                end
                if (eop == OP_ADD || eop == OP_NOR) begin
                    d = dest_of(r_em.ins);
                    if (d.r == ra_of(cur)) a = r_em.alu;
                    if (useb && d.r == rb_of(cur)) b = r_em.alu;
                end
                case (op)
                    OP_ADD:  n_em.alu = a + b;
                    OP_NOR:  n_em.alu = ~(a | b);
                    OP_BEQ:  n_em.eq  = (a == b);
                    OP_LW:   n_em.alu = a + r_de.off;
                    default: begin
                        n_em.alu = a + r_de.off;
                        n_em.vb  = b;
                    end
                endcase
            end

            n_mw.ins = r_em.ins;
            wop = op_of(r_em.ins);
            ad  = r_em.alu[AW-1:0];
            if (wop == OP_LW) begin
                n_mw.data = lw_word;
            end else if (wop == OP_SW) begin
                n_res.store_valid = 1'b1;
                n_res.store_addr  = 16'(ad);
                n_res.store_data  = r_em.vb;
            end else if (wop == OP_BEQ) begin
                if (r_em.eq) begin
                    n_pc      = r_em.target[15:0];
                    n_em.ins  = NOOP_WORD;
                    n_de.ins  = NOOP_WORD;
                    n_fd.ins  = NOOP_WORD;
                end
            end else if (wop == OP_ADD || wop == OP_NOR) begin
                n_mw.data = r_em.alu;
            end

            d = dest_of(r_mw.ins);
            if (d.v) begin
                rf_we = 1'b1;
                rf_wa = d.r;
                n_res.wb_valid = 1'b1;
                n_res.wb_reg   = d.r;
                n_res.wb_data  = r_mw.data;
            end
        end

        if (acc && i_in.func == FN_RREG) n_res.read_value = r_rf[i_in.addr[2:0]];
        n_res.halted      = (op_of(run ? n_mw.ins : r_mw.ins) == OP_HALT);
        n_res.pc_now      = n_pc;
        n_res.cycle_count = n_cyc;
    end

    always_comb begin
        im_we  = r_clearing || (acc && i_in.func == FN_LOAD);
        im_wa  = r_clearing ? r_clr_addr : i_in.addr[AW-1:0];
        im_wd  = r_clearing ? 32'd0 : i_in.load_value;
        dm_we  = im_we || (run && op_of(r_em.ins) == OP_SW);
        dm_wa  = (run && op_of(r_em.ins) == OP_SW) ? r_em.alu[AW-1:0] : im_wa;
        dm_wd  = (run && op_of(r_em.ins) == OP_SW) ? r_em.vb : im_wd;
        im_ra  = n_pc[AW-1:0];
        dma_ra = n_em.alu[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (im_we) r_imem[im_wa] <= im_wd;
        r_imem_q <= r_imem[im_ra];
        if (dm_we) r_dmem[dm_wa] <= dm_wd;
        r_dma_q <= r_dmem[dma_ra];
        if (acc && i_in.func == FN_RDM) r_dmb_q <= r_dmem[i_in.addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_byp  <= 1'b1;
            r_if_bd   <= 32'd0;
            r_dma_byp <= 1'b1;
            r_dma_bd  <= 32'd0;
        end else begin
            r_if_byp  <= r_clearing || (im_we && im_wa == im_ra);
            r_if_bd   <= r_clearing ? 32'd0 : im_wd;
            r_dma_byp <= r_clearing || (dm_we && dm_wa == dma_ra);
            r_dma_bd  <= r_clearing ? 32'd0 : dm_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_pc       <= 16'd0;
            r_cyc      <= 32'd0;
            r_fd       <= '{ins: NOOP_WORD, pcp1: 16'd0};
            r_de       <= '{ins: NOOP_WORD, default: '0};
            r_em       <= '{ins: NOOP_WORD, default: '0};
            r_mw       <= '{ins: NOOP_WORD, data: 32'd0};
            r_we       <= '{ins: NOOP_WORD, data: 32'd0};
            for (int i = 0; i < 8; i++) r_rf[i] <= 32'd0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MEM_WORDS - 1)) r_clearing <= 1'b0;
            end
            if (run) begin
                r_pc  <= n_pc;
                r_cyc <= n_cyc;
                r_fd  <= n_fd;
                r_de  <= n_de;
                r_em  <= n_em;
                r_mw  <= n_mw;
                r_we  <= r_mw;
                if (rf_we) r_rf[rf_wa] <= r_mw.data;
            end
        end
    end

    // pending result, then two-entry output queue
    always_comb begin
        p_res = r_p;
        if (r_p_dsel) p_res.read_value = r_dmb_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
        end else begin
            if (acc)       r_p_valid <= 1'b1;
            else if (push) r_p_valid <= 1'b0;
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p      <= n_res;
            r_p_dsel <= (i_in.func == FN_RDM);
        end
        if (push) r_q[r_wp] <= p_res;
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_q[r_rp];

endmodule
`default_nettype wire

// File: rtl/fspc_chk.sv
// Checker: port-level properties of the pipeline, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fspc_chk import fspc_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire t_in  i_in,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output transfer changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in))
        else $error("stalled input transfer changed");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_stall)
        else $error("input taken during memory clear");

    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.wb_valid |-> o_out.wb_reg == 3'd0 && o_out.wb_data == 32'sd0)
        else $error("write-back fields set without write-back");

    a_st_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.store_valid |->
            o_out.store_addr == 16'd0 && o_out.store_data == 32'sd0)
        else $error("store fields set without store");

endmodule

bind five_stage_pipelined_cpu fspc_chk u_fspc_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .i_in(i_in), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
);
`default_nettype wire
